// ----- rtl/ostt_pkg.sv -----
package ostt_pkg;

  localparam int SLOTS  = 16;
  localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int ID_W   = 32;
  localparam int TIME_W = 48;
  localparam int DLY_W  = 32;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
  localparam logic [ID_W-1:0]   ID_MAX   = {ID_W{1'b1}};

  // input modes
  localparam logic [1:0] MODE_SCHED    = 2'd0;
  localparam logic [1:0] MODE_CANCEL   = 2'd1;
  localparam logic [1:0] MODE_TICK     = 2'd2;
  localparam logic [1:0] MODE_SHUTDOWN = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_GRANT  = 2'd0;
  localparam logic [1:0] KIND_REJECT = 2'd1;
  localparam logic [1:0] KIND_FIRED  = 2'd2;

  // cell operations, broadcast to the whole chain
  localparam logic [2:0] OP_HOLD    = 3'd0;
  localparam logic [2:0] OP_LOAD    = 3'd1;
  localparam logic [2:0] OP_MARK    = 3'd2;
  localparam logic [2:0] OP_CLEAR   = 3'd3;
  localparam logic [2:0] OP_ROTATE  = 3'd4;
  localparam logic [2:0] OP_COMPACT = 3'd5;

  typedef struct packed {
    logic              valid;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] expiry;
  } entry_t;

  typedef struct packed {
    logic [2:0]        op;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] expiry;
    logic [ID_W-1:0]   handle;
  } ctrl_t;

endpackage

// ----- rtl/ostt_cell.sv -----
module ostt_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  ostt_pkg::ctrl_t ctrl_i,
  input  logic            prev_valid_i,
  input  logic            hole_i,
  input  ostt_pkg::entry_t next_i,
  output ostt_pkg::entry_t ent_o,
  output logic            hole_o
);

  logic                          valid_r;
  logic [ostt_pkg::ID_W-1:0]     id_r;
  logic [ostt_pkg::TIME_W-1:0]   exp_r;
  ostt_pkg::entry_t              ent_nxt;

  assign ent_o  = '{valid: valid_r, id: id_r, expiry: exp_r};
  // a hole at or below this cell pulls this cell's neighbor down
  assign hole_o = hole_i | ~valid_r;

  always_comb begin
    ent_nxt = ent_o;
    unique case (ctrl_i.op)
      ostt_pkg::OP_HOLD: begin
      end
      ostt_pkg::OP_LOAD: begin
        // first free cell takes the new timer
        if (!valid_r && prev_valid_i) begin
          ent_nxt = '{valid: 1'b1, id: ctrl_i.id, expiry: ctrl_i.expiry};
        end
      end
      ostt_pkg::OP_MARK: begin
        if (valid_r && (id_r == ctrl_i.handle)) begin
          ent_nxt.valid = 1'b0;
        end
      end
      ostt_pkg::OP_CLEAR: begin
        ent_nxt.valid = 1'b0;
      end
      ostt_pkg::OP_ROTATE: begin
        ent_nxt = next_i;
      end
      ostt_pkg::OP_COMPACT: begin
        if (hole_o) begin
          ent_nxt = next_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= ent_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    id_r  <= ent_nxt.id;
    exp_r <= ent_nxt.expiry;
  end

endmodule

// ----- rtl/one_shot_timer_table.sv -----
// Schedule: result registered in the cycle after the transaction; one item every cycle
//   while the output is not stalled. Cancel: a mark step, then a compaction sweep down
//   the cell chain. Tick: one rotation of the chain with a head-of-chain compare, a flush
//   of the held result, then the compaction sweep; output stalls stretch it.
// Shutdown: clears every cell and stops later schedules. Synchronous active-low reset
//   empties the table, time 0, next handle 1, not stopped; no clearing pass.
module one_shot_timer_table (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_mode,
  input  logic [ostt_pkg::DLY_W-1:0]    in_delay,
  input  logic [ostt_pkg::ID_W-1:0]     in_handle,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_kind,
  output logic [ostt_pkg::ID_W-1:0]     out_timer_id,
  output logic                          out_last
);

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_ROT     = 2'd1;
  localparam logic [1:0] ST_FLUSH   = 2'd2;
  localparam logic [1:0] ST_COMPACT = 2'd3;

  localparam logic [ostt_pkg::IDX_W-1:0] CNT_END = ostt_pkg::IDX_W'(ostt_pkg::SLOTS - 1);

  logic [1:0]                     state_r, state_nxt;
  logic [ostt_pkg::IDX_W-1:0]     cnt_r, cnt_nxt;
  logic [ostt_pkg::TIME_W-1:0]    time_now_r, time_now_nxt;
  logic [ostt_pkg::ID_W-1:0]      next_handle_r, next_handle_nxt;
  logic                           stopped_r, stopped_nxt;
  logic                           pend_v_r, pend_v_nxt;
  logic [ostt_pkg::ID_W-1:0]      pend_id_r, pend_id_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [1:0]                     out_kind_r, out_kind_nxt;
  logic [ostt_pkg::ID_W-1:0]      out_id_r, out_id_nxt;
  logic                           out_last_r, out_last_nxt;

  ostt_pkg::ctrl_t                ctrl;
  ostt_pkg::entry_t               ent      [ostt_pkg::SLOTS];
  ostt_pkg::entry_t               nxt_in   [ostt_pkg::SLOTS];
  logic                           prev_v   [ostt_pkg::SLOTS];
  logic                           hole_in  [ostt_pkg::SLOTS];
  logic                           hole_out [ostt_pkg::SLOTS];
  logic [ostt_pkg::SLOTS-1:0]     valid_vec;

  ostt_pkg::entry_t               head;
  ostt_pkg::entry_t               tail_feed;
  logic                           head_due;
  logic [ostt_pkg::TIME_W:0]      exp_sum;
  logic [ostt_pkg::TIME_W-1:0]    exp_sat;
  logic                           can_load;
  logic                           acc;

  genvar g;
  generate
    for (g = 0; g < ostt_pkg::SLOTS; g++) begin : g_cell
      if (g == 0) begin : g_first
        assign prev_v[g]  = 1'b1;
        assign hole_in[g] = 1'b0;
      end else begin : g_mid
        assign prev_v[g]  = ent[g-1].valid;
        assign hole_in[g] = hole_out[g-1];
      end
      if (g == ostt_pkg::SLOTS - 1) begin : g_last
        assign nxt_in[g] = tail_feed;
      end else begin : g_inner
        assign nxt_in[g] = ent[g+1];
      end
      assign valid_vec[g] = ent[g].valid;

      ostt_cell u_cell (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl_i       (ctrl),
        .prev_valid_i (prev_v[g]),
        .hole_i       (hole_in[g]),
        .next_i       (nxt_in[g]),
        .ent_o        (ent[g]),
        .hole_o       (hole_out[g])
      );
    end
  endgenerate

  assign head     = ent[0];
  assign head_due = head.valid && (head.expiry <= time_now_r);

  // rotating: the head wraps to the tail, dropped if it fires; compacting: empty fill
  always_comb begin
    tail_feed = '{valid: 1'b0, id: '0, expiry: '0};
    if (state_r == ST_ROT) begin
      tail_feed = '{valid: head.valid & ~head_due, id: head.id, expiry: head.expiry};
    end
  end

  assign exp_sum = {1'b0, time_now_r} + {{(ostt_pkg::TIME_W + 1 - ostt_pkg::DLY_W){1'b0}}, in_delay};
  assign exp_sat = exp_sum[ostt_pkg::TIME_W] ? ostt_pkg::TIME_MAX
                                             : exp_sum[ostt_pkg::TIME_W-1:0];

  assign can_load = ~out_valid_r | ~out_stall;
  assign in_stall = (state_r != ST_IDLE) | ~can_load;
  assign acc      = in_valid & ~in_stall;

  assign out_valid    = out_valid_r;
  assign out_kind     = out_kind_r;
  assign out_timer_id = out_id_r;
  assign out_last     = out_last_r;

  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    time_now_nxt    = time_now_r;
    next_handle_nxt = next_handle_r;
    stopped_nxt     = stopped_r;
    pend_v_nxt      = pend_v_r;
    pend_id_nxt     = pend_id_r;
    out_valid_nxt   = out_valid_r & out_stall;
    out_kind_nxt    = out_kind_r;
    out_id_nxt      = out_id_r;
    out_last_nxt    = out_last_r;
    ctrl.op         = ostt_pkg::OP_HOLD;
    ctrl.id         = next_handle_r;
    ctrl.expiry     = exp_sat;
    ctrl.handle     = in_handle;

    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          unique case (in_mode)
            ostt_pkg::MODE_SCHED: begin
              out_valid_nxt = 1'b1;
              out_last_nxt  = 1'b1;
              if (stopped_r || ent[ostt_pkg::SLOTS-1].valid) begin
                out_kind_nxt = ostt_pkg::KIND_REJECT;
                out_id_nxt   = '0;
              end else begin
                out_kind_nxt    = ostt_pkg::KIND_GRANT;
                out_id_nxt      = next_handle_r;
                ctrl.op         = ostt_pkg::OP_LOAD;
                next_handle_nxt = (next_handle_r == ostt_pkg::ID_MAX) ?
                                  ostt_pkg::ID_W'(1) : next_handle_r + ostt_pkg::ID_W'(1);
              end
            end
            ostt_pkg::MODE_CANCEL: begin
              if (in_handle != '0) begin
                ctrl.op   = ostt_pkg::OP_MARK;
                state_nxt = ST_COMPACT;
                cnt_nxt   = '0;
              end
            end
            ostt_pkg::MODE_TICK: begin
              if (time_now_r != ostt_pkg::TIME_MAX) begin
                time_now_nxt = time_now_r + ostt_pkg::TIME_W'(1);
              end
              state_nxt = ST_ROT;
              cnt_nxt   = '0;
            end
            ostt_pkg::MODE_SHUTDOWN: begin
              ctrl.op     = ostt_pkg::OP_CLEAR;
              stopped_nxt = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      ST_ROT: begin
        if (can_load) begin
          ctrl.op = ostt_pkg::OP_ROTATE;
          // hold one fired id back so the final one can carry last
          if (head_due) begin
            if (pend_v_r) begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = ostt_pkg::KIND_FIRED;
              out_id_nxt    = pend_id_r;
              out_last_nxt  = 1'b0;
            end
            pend_v_nxt  = 1'b1;
            pend_id_nxt = head.id;
          end
          cnt_nxt = cnt_r + ostt_pkg::IDX_W'(1);
          if (cnt_r == CNT_END) begin
            state_nxt = ST_FLUSH;
            cnt_nxt   = '0;
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_v_r) begin
          state_nxt = ST_COMPACT;
        end else if (can_load) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = ostt_pkg::KIND_FIRED;
          out_id_nxt    = pend_id_r;
          out_last_nxt  = 1'b1;
          pend_v_nxt    = 1'b0;
          state_nxt     = ST_COMPACT;
        end
      end
      ST_COMPACT: begin
        ctrl.op = ostt_pkg::OP_COMPACT;
        cnt_nxt = cnt_r + ostt_pkg::IDX_W'(1);
        if (cnt_r == CNT_END) begin
          state_nxt = ST_IDLE;
          cnt_nxt   = '0;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      cnt_r         <= '0;
      time_now_r    <= '0;
      next_handle_r <= ostt_pkg::ID_W'(1);
      stopped_r     <= 1'b0;
      pend_v_r      <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      cnt_r         <= cnt_nxt;
      time_now_r    <= time_now_nxt;
      next_handle_r <= next_handle_nxt;
      stopped_r     <= stopped_nxt;
      pend_v_r      <= pend_v_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_id_r  <= pend_id_nxt;
    out_kind_r <= out_kind_nxt;
    out_id_r   <= out_id_nxt;
    out_last_r <= out_last_nxt;
  end

  logic prefix_ok;
  assign prefix_ok = ((valid_vec + {{(ostt_pkg::SLOTS-1){1'b0}}, 1'b1}) & valid_vec) == '0;

`ifndef SYNTHESIS
  a_prefix_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> prefix_ok)
    else $error("timer table not compacted in idle");

  a_no_pending_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !pend_v_r)
    else $error("fired timer left pending");

  a_reject_zero_id: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == ostt_pkg::KIND_REJECT) |-> (out_id_r == '0))
    else $error("rejected schedule carries a handle");

  a_shutdown_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_mode == ostt_pkg::MODE_SHUTDOWN) |=> (valid_vec == '0) && stopped_r)
    else $error("shutdown left timers in table");
`endif

endmodule
